@@ rtl/text_line_formatter_top_macros.svh @@
// assertion macros for the text line formatter checker
`ifndef TEXT_LINE_FORMATTER_TOP_MACROS_SVH
`define TEXT_LINE_FORMATTER_TOP_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define TLF_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, quiet while reset is high
`define TLF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/tlf_pkg.sv @@
// shared constants, types and codes of the text line formatter
`timescale 1ns / 1ps

package tlf_pkg;

   localparam int DIGITS      = 8;
   localparam int MIN_WIDTH   = 6;
   localparam int CHAR_MAX    = 4;
   localparam int MAX_RUN     = DIGITS + 5;
   localparam int RUN_CNT_W   = $clog2(MAX_RUN + 1);
   localparam int NUM_LEN_W   = $clog2(DIGITS + 1);
   localparam int CHAR_LEN_W  = $clog2(CHAR_MAX + 1);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 1;

   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_DASH   = 8'h2D;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_QUEST  = 8'h3F;
   localparam logic [7:0] CHR_UPPER_I = 8'h49;
   localparam logic [7:0] CHR_UPPER_M = 8'h4D;
   localparam logic [7:0] CHR_CARET  = 8'h5E;
   localparam logic [7:0] CHR_DEL    = 8'd127;
   localparam logic [7:0] LOW7_MASK  = 8'b0111_1111;
   localparam logic [7:0] CTRL_LIMIT = 8'd31;
   localparam logic [7:0] CARET_OFFSET = 8'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUMBER_ALL       = 3'd0,
      CSR_NUMBER_NONBLANK  = 3'd1,
      CSR_SQUEEZE_BLANK    = 3'd2,
      CSR_SHOW_ENDS        = 3'd3,
      CSR_SHOW_TABS        = 3'd4,
      CSR_SHOW_NONPRINTING = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic number_all;
      logic number_nonblank;
      logic squeeze_blank;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

   typedef logic [DIGITS-1:0][3:0] bcd_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic step;
   } count_ctl_type;

   typedef struct packed {
      logic [CHAR_MAX-1:0][7:0] bytes;
      logic [CHAR_LEN_W-1:0]    len;
   } char_run_type;

   typedef struct packed {
      logic [MAX_RUN-1:0][7:0] bytes;
      logic [RUN_CNT_W-1:0]    len;
   } run_type;

endpackage

@@ rtl/tlf_channels.sv @@
// valid/ready channel interfaces for input bytes and formatted output bytes
`timescale 1ns / 1ps

interface tlf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_file;

   modport source (output valid, output data_byte, output first_of_file, input ready);
   modport sink   (input valid, input data_byte, input first_of_file, output ready);
endinterface

interface tlf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ rtl/tlf_char_expand.sv @@
// expansion of one text byte into its visible form
`timescale 1ns / 1ps

module tlf_char_expand import tlf_pkg::*; (
   input  logic [7:0]   data_byte,
   input  cfg_type      cfg,
   output char_run_type char_run
);

   logic [7:0] low7;
   logic [7:0] caret_char;
   logic       printable;
   logic       is_nl;
   logic       is_tab;

   assign low7       = data_byte & LOW7_MASK;
   assign printable  = (low7 > CTRL_LIMIT) && (low7 < CHR_DEL);
   assign caret_char = (low7 == CHR_DEL) ? CHR_QUEST : (low7 + CARET_OFFSET);
   assign is_nl      = (data_byte == CHR_NL);
   assign is_tab     = (data_byte == CHR_TAB);

   always_comb begin
      char_run          = '0;
      char_run.bytes[0] = data_byte;
      char_run.len      = CHAR_LEN_W'(1);
      priority if (is_nl && cfg.show_ends) begin
         char_run.bytes[0] = CHR_DOLLAR;
         char_run.bytes[1] = CHR_NL;
         char_run.len      = CHAR_LEN_W'(2);
      end else if (is_tab && cfg.show_tabs) begin
         char_run.bytes[0] = CHR_CARET;
         char_run.bytes[1] = CHR_UPPER_I;
         char_run.len      = CHAR_LEN_W'(2);
      end else if (cfg.show_nonprinting && !is_nl && !is_tab) begin
         if (data_byte[7]) begin
            char_run.bytes[0] = CHR_UPPER_M;
            char_run.bytes[1] = CHR_DASH;
            if (printable) begin
               char_run.bytes[2] = low7;
               char_run.len      = CHAR_LEN_W'(3);
            end else begin
               char_run.bytes[2] = CHR_CARET;
               char_run.bytes[3] = caret_char;
               char_run.len      = CHAR_LEN_W'(4);
            end
         end else if (printable) begin
            char_run.bytes[0] = low7;
            char_run.len      = CHAR_LEN_W'(1);
         end else begin
            char_run.bytes[0] = CHR_CARET;
            char_run.bytes[1] = caret_char;
            char_run.len      = CHAR_LEN_W'(2);
         end
      end else begin
         char_run.bytes[0] = data_byte;
         char_run.len      = CHAR_LEN_W'(1);
      end
   end

endmodule

@@ rtl/tlf_line_counter.sv @@
// saturating bcd line counter and right-aligned line number field
`timescale 1ns / 1ps

module tlf_line_counter import tlf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  count_ctl_type           ctl,
   output logic [DIGITS-1:0][7:0]  num_bytes,
   output logic [NUM_LEN_W-1:0]    num_len
);

   bcd_type                   count_ff;
   bcd_type                   count_in;
   bcd_type                   count_base;
   bcd_type                   count_stepped;
   logic                      full;
   logic                      carry;
   logic [NUM_LEN_W-1:0]      sig;
   logic [NUM_LEN_W-1:0]      pad;
   logic [NUM_LEN_W-1:0]      shift;
   logic [4*DIGITS-1:0]       aligned;

   assign count_base = ctl.clear ? '0 : count_ff;

   // ripple the carry through the digits, hold at all nines
   always_comb begin
      full          = 1'b1;
      carry         = 1'b1;
      count_stepped = count_base;
      for (int i = 0; i < DIGITS; i++) begin
         if (count_base[i] != 4'd9) full = 1'b0;
      end
      for (int i = 0; i < DIGITS; i++) begin
         if (carry) begin
            if (count_base[i] >= 4'd9) begin
               count_stepped[i] = 4'd0;
            end else begin
               count_stepped[i] = count_base[i] + 4'd1;
               carry            = 1'b0;
            end
         end
      end
      if (full) count_stepped = count_base;
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.load) count_in = ctl.step ? count_stepped : count_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // significant digits, at least one
   always_comb begin
      sig = NUM_LEN_W'(1);
      for (int i = 0; i < DIGITS; i++) begin
         if (count_stepped[i] != 4'd0) sig = NUM_LEN_W'(i + 1);
      end
   end

   assign num_len = (sig < NUM_LEN_W'(MIN_WIDTH)) ? NUM_LEN_W'(MIN_WIDTH) : sig;
   assign pad     = num_len - sig;
   assign shift   = NUM_LEN_W'(DIGITS) - num_len;
   assign aligned = count_stepped << {shift, 2'b00};

   always_comb begin
      for (int p = 0; p < DIGITS; p++) begin
         if (NUM_LEN_W'(p) >= num_len) begin
            num_bytes[p] = 8'h00;
         end else if (NUM_LEN_W'(p) < pad) begin
            num_bytes[p] = CHR_SPACE;
         end else begin
            num_bytes[p] = CHR_ZERO + {4'd0, aligned[4*(DIGITS-1-p) +: 4]};
         end
      end
   end

endmodule

@@ rtl/tlf_run_buffer.sv @@
// result register holding one formatted run, drained a byte per transaction
`timescale 1ns / 1ps

module tlf_run_buffer import tlf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  run_type         run,
   output logic            free,
   tlf_rsp_if.source       rsp
);

   logic                    valid_ff;
   logic                    valid_in;
   logic [MAX_RUN-1:0][7:0] bytes_ff;
   logic [MAX_RUN-1:0][7:0] bytes_in;
   logic [RUN_CNT_W-1:0]    remain_ff;
   logic [RUN_CNT_W-1:0]    remain_in;
   logic                    last;

   assign last = (remain_ff == RUN_CNT_W'(1));
   assign free = !valid_ff || (rsp.ready && last);

   always_comb begin
      valid_in  = valid_ff;
      bytes_in  = bytes_ff;
      remain_in = remain_ff;
      if (valid_ff && rsp.ready) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            bytes_in  = bytes_ff >> 8;
            remain_in = remain_ff - RUN_CNT_W'(1);
         end
      end
      if (load) begin
         valid_in  = 1'b1;
         bytes_in  = run.bytes;
         remain_in = run.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         remain_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = bytes_ff[0];
   assign rsp.last_of_run = last;

endmodule

@@ rtl/text_line_formatter_top.sv @@
// top level of the text line formatter: line numbering and visible control bytes
// the first byte of a run shows on rsp in the cycle after its req transaction
// a run drains one byte per rsp transaction; the next
//    req transaction is taken in the cycle the last byte is taken, so 1 byte/cycle max
// reset: synchronous, clears settings, counter and marks; run buffer empties
`timescale 1ns / 1ps

module text_line_formatter_top import tlf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tlf_req_if.sink               req_ch,
   tlf_rsp_if.source             rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // settings registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // line state marks
   logic at_start_ff;
   logic at_start_in;
   logic prev_blank_ff;
   logic prev_blank_in;

   logic                     accept;
   logic                     buf_free;
   logic                     start_eff;
   logic                     prev_eff;
   logic                     blank;
   logic                     squeezed;
   logic                     numbered;
   count_ctl_type            count_ctl;
   logic [DIGITS-1:0][7:0]   num_bytes;
   logic [NUM_LEN_W-1:0]     num_len;
   char_run_type             char_run;
   run_type                  run;
   logic [MAX_RUN*8-1:0]     tail_flat;

   // settings write, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NUMBER_ALL:       cfg_in.number_all       = csr_write_data[0];
            CSR_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_write_data[0];
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_write_data[0];
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_write_data[0];
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_write_data[0];
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_write_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // input handshake: take a byte whenever the run buffer frees up this cycle
   assign req_ch.ready = buf_free;
   assign accept       = req_ch.valid && buf_free;

   // a first-of-file byte sees a fresh line start and a cleared blank mark
   assign start_eff = req_ch.first_of_file || at_start_ff;
   assign prev_eff  = !req_ch.first_of_file && prev_blank_ff;
   assign blank     = (req_ch.data_byte == CHR_NL);

   // repeated blank line under squeeze: no output, marks stay as they are
   assign squeezed = start_eff && cfg_ff.squeeze_blank && blank && prev_eff;

   // nonblank mode wins over number-all
   assign numbered = start_eff && !squeezed &&
                     (cfg_ff.number_nonblank ? !blank : cfg_ff.number_all);

   always_comb begin
      at_start_in   = at_start_ff;
      prev_blank_in = prev_blank_ff;
      if (accept) begin
         if (squeezed) begin
            at_start_in   = 1'b1;
            prev_blank_in = 1'b1;
         end else begin
            at_start_in   = blank;
            prev_blank_in = start_eff ? blank : prev_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         at_start_ff   <= 1'b1;
         prev_blank_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         at_start_ff   <= at_start_in;
         prev_blank_ff <= prev_blank_in;
      end
   end

   assign count_ctl.load  = accept;
   assign count_ctl.clear = req_ch.first_of_file;
   assign count_ctl.step  = numbered;

   tlf_line_counter u_line_counter (
      .clock     (clock),
      .reset     (reset),
      .ctl       (count_ctl),
      .num_bytes (num_bytes),
      .num_len   (num_len)
   );

   tlf_char_expand u_char_expand (
      .data_byte (req_ch.data_byte),
      .cfg       (cfg_ff),
      .char_run  (char_run)
   );

   // run layout: number field, tab, then the expanded byte; without a number
   // the expanded byte starts the run
   assign tail_flat = (MAX_RUN*8)'({char_run.bytes, CHR_TAB});

   always_comb begin
      if (numbered) begin
         run.bytes = (MAX_RUN*8)'(num_bytes) | (tail_flat << {num_len, 3'b000});
         run.len   = RUN_CNT_W'(num_len) + RUN_CNT_W'(1) + RUN_CNT_W'(char_run.len);
      end else begin
         run.bytes = (MAX_RUN*8)'(char_run.bytes);
         run.len   = RUN_CNT_W'(char_run.len);
      end
   end

   // result register and byte-wise drain toward the rsp channel
   tlf_run_buffer u_run_buffer (
      .clock (clock),
      .reset (reset),
      .load  (accept && !squeezed),
      .run   (run),
      .free  (buf_free),
      .rsp   (rsp_ch)
   );

endmodule

@@ rtl/tlf_checker.sv @@
// port-level checker for the text line formatter, bound to the top level
`timescale 1ns / 1ps
`include "text_line_formatter_top_macros.svh"

module tlf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       last_of_run
);

   `TLF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_byte) && $stable(last_of_run))
   `TLF_ASSERT_NEXT(a_run_continues, rsp_valid && rsp_ready && !last_of_run, rsp_valid)
   `TLF_ASSERT_IMPLIES(a_ready_when_empty, !rsp_valid, req_ready)
   `TLF_ASSERT_IMPLIES(a_ready_only_at_end, req_ready, !rsp_valid || (rsp_ready && last_of_run))

endmodule

bind text_line_formatter_top tlf_checker u_tlf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .out_byte    (rsp_ch.out_byte),
   .last_of_run (rsp_ch.last_of_run)
);

@@ verif/testbench.sv @@
// self-checking testbench of the text line formatter: a directed table, then random text streams
`timescale 1ns / 1ps

module testbench import tlf_pkg::*; ();

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 3;
   // longest stretch with no transaction on either side before the run is declared hung
   localparam int IDLE_LIMIT      = 2000;
   // settle time after the drain, to catch any stray output
   localparam int SETTLE_CYCLES   = 4;
   localparam int RANDOM_ITEMS    = 200;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = RANDOM_ITEMS / PHASES;
   localparam int REPORT_LIMIT    = 10;

   // register indexes past the six settings; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // bit order: number_all, number_nonblank, squeeze_blank, show_ends, show_tabs,
   // show_nonprinting
   localparam cfg_type CFG_PLAIN        = 6'b000000;
   localparam cfg_type CFG_EVERYTHING   = 6'b111111;
   localparam cfg_type CFG_LINES_ENDS   = 6'b100100;
   localparam cfg_type CFG_NONPRINT     = 6'b000001;
   localparam cfg_type CFG_TABS_SQUEEZE = 6'b001010;

   // where a directed row takes its expected bytes from
   typedef enum bit {
      FROM_PREDICTOR,
      FROM_TABLE
   } answer_type;

   typedef struct {
      cfg_type    cfg;
      logic [7:0] data_byte;
      logic       first_of_file;
      answer_type answer;
      string      typed_run;
   } directed_row_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } out_item_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   tlf_req_if req_ch ();
   tlf_rsp_if rsp_ch ();

   text_line_formatter_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // formatter state as the predictor sees it
   cfg_type    model_cfg;
   bcd_type    model_count;
   logic       model_line_start;
   logic       model_prev_blank;

   // bytes produced by the last predicted transaction, and the outstanding output bytes
   logic [7:0]   formatted_run [$];
   out_item_type pending_bytes [$];

   directed_row_type directed_rows [26];

   int mismatches;
   int idle_cycles;
   int bytes_sent;
   int bytes_received;
   int numbered_lines;
   int squeezed_lines;
   int settings_applied;

   // -------------------------------------------------------------------------
   // predictor: formats one input byte into formatted_run and advances the state
   // -------------------------------------------------------------------------
   function automatic void format_byte(input logic [7:0] c, input logic first_of_file);
      logic       blank;
      logic       numbered;
      logic       full;
      logic       carry;
      int         sig;
      logic [7:0] low7;
      formatted_run = {};
      // new file: counter and marks restart before this byte
      if (first_of_file) begin
         model_count      = '0;
         model_line_start = 1'b1;
         model_prev_blank = 1'b0;
      end
      if (model_line_start) begin
         blank = (c == CHR_NL);
         // a blank line right after a blank line vanishes, marks untouched
         if (model_cfg.squeeze_blank && blank && model_prev_blank) begin
            return;
         end
         model_prev_blank = blank;
         // nonblank numbering overrides number-all
         numbered = model_cfg.number_nonblank ? !blank : model_cfg.number_all;
         if (numbered) begin
            numbered_lines++;
            // decimal increment that sticks at all nines
            full = 1'b1;
            for (int i = 0; i < DIGITS; i++) begin
               if (model_count[i] != 4'd9) full = 1'b0;
            end
            if (!full) begin
               carry = 1'b1;
               for (int i = 0; i < DIGITS; i++) begin
                  if (carry) begin
                     if (model_count[i] == 4'd9) begin
                        model_count[i] = 4'd0;
                     end else begin
                        model_count[i] = model_count[i] + 4'd1;
                        carry          = 1'b0;
                     end
                  end
               end
            end
            // right-aligned in six places, longer numbers in full, then a tab
            sig = 1;
            for (int i = 0; i < DIGITS; i++) begin
               if (model_count[i] != 4'd0) sig = i + 1;
            end
            for (int i = sig; i < MIN_WIDTH; i++) formatted_run.push_back(CHR_SPACE);
            for (int i = sig; i > 0; i--) begin
               formatted_run.push_back(CHR_ZERO + {4'd0, model_count[i-1]});
            end
            formatted_run.push_back(CHR_TAB);
         end
      end
      if (c == CHR_NL && model_cfg.show_ends) begin
         formatted_run.push_back(CHR_DOLLAR);
         formatted_run.push_back(CHR_NL);
      end else if (c == CHR_TAB && model_cfg.show_tabs) begin
         formatted_run.push_back(CHR_CARET);
         formatted_run.push_back(CHR_UPPER_I);
      end else if (c != CHR_NL && c != CHR_TAB && model_cfg.show_nonprinting) begin
         if (c[7]) begin
            formatted_run.push_back(CHR_UPPER_M);
            formatted_run.push_back(CHR_DASH);
         end
         // low seven bits, in caret form unless printable
         low7 = c & LOW7_MASK;
         if (low7 > CTRL_LIMIT && low7 < CHR_DEL) begin
            formatted_run.push_back(low7);
         end else begin
            formatted_run.push_back(CHR_CARET);
            formatted_run.push_back(low7 == CHR_DEL ? CHR_QUEST : low7 + CARET_OFFSET);
         end
      end else begin
         formatted_run.push_back(c);
      end
      model_line_start = (c == CHR_NL);
   endfunction

   // -------------------------------------------------------------------------
   // sender side, called and returning at a falling edge
   // -------------------------------------------------------------------------
   // offer one byte, wait for its transaction, then queue what it must produce
   task automatic send_byte(input logic [7:0] data_byte, input logic first_of_file,
                            input answer_type answer, input string typed_run);
      req_ch.valid         <= 1'b1;
      req_ch.data_byte     <= data_byte;
      req_ch.first_of_file <= first_of_file;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
      format_byte(data_byte, first_of_file);
      // hand-typed rows replace the predicted bytes, the state still moves on
      if (answer == FROM_TABLE) begin
         formatted_run = {};
         for (int i = 0; i < typed_run.len(); i++) formatted_run.push_back(typed_run[i]);
      end
      if (formatted_run.size() == 0) squeezed_lines++;
      foreach (formatted_run[i]) begin
         pending_bytes.push_back('{out_byte: formatted_run[i],
                                   last_of_run: (i == formatted_run.size() - 1)});
      end
   endtask

   // hold the sender until every expected byte is out, then let the block settle
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write every register, plus both spare indexes with random data, back to back
   task automatic apply_settings(input cfg_type s);
      logic [CSR_IDX_W-1:0] order [8];
      logic                 bits [8];
      order = '{CSR_NUMBER_ALL, CSR_NUMBER_NONBLANK, CSR_SQUEEZE_BLANK, CSR_SHOW_ENDS,
                CSR_SHOW_TABS, CSR_SHOW_NONPRINTING, CSR_SPARE_LO, CSR_SPARE_HI};
      bits  = '{s.number_all, s.number_nonblank, s.squeeze_blank, s.show_ends,
                s.show_tabs, s.show_nonprinting, 1'($urandom), 1'($urandom)};
      foreach (order[k]) begin
         csr_write_enable <= 1'b1;
         csr_index        <= order[k];
         csr_write_data   <= bits[k];
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      model_cfg = s;
      settings_applied++;
   endtask

   // -------------------------------------------------------------------------
   // receiver: rotating stall pattern, redrawn now and then
   // -------------------------------------------------------------------------
   logic [31:0] stall_pattern;
   int          pattern_age = 0;

   always @(negedge clock) begin
      if (pattern_age == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern = '1;                  // no stalls at all
            1:       stall_pattern = $urandom;            // even mix
            2:       stall_pattern = $urandom & $urandom; // mostly stalled
            default: stall_pattern = $urandom | $urandom; // mostly ready
         endcase
         // at least one ready per rotation keeps every stall bounded
         stall_pattern[0] = 1'b1;
         pattern_age      = $urandom_range(16, 96);
      end
      pattern_age--;
      rsp_ch.ready  <= stall_pattern[0];
      stall_pattern  = {stall_pattern[0], stall_pattern[31:1]};
   end

   // -------------------------------------------------------------------------
   // checker and watchdog, sampled at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      out_item_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            bytes_received++;
            if (pending_bytes.size() == 0) begin
               // output byte with nothing outstanding
               if (mismatches < REPORT_LIMIT) begin
                  $display("unexpected output byte %02h last %0b at %0t",
                           rsp_ch.out_byte, rsp_ch.last_of_run, $realtime);
               end
               mismatches++;
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_ch.out_byte !== want.out_byte ||
                   rsp_ch.last_of_run !== want.last_of_run) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("mismatch at %0t: byte exp %02h got %02h, last exp %0b got %0b",
                              $realtime, want.out_byte, rsp_ch.out_byte,
                              want.last_of_run, rsp_ch.last_of_run);
                  end
                  mismatches++;
               end
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d bytes outstanding",
                     idle_cycles, pending_bytes.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin
      cfg_type     phase_cfg;
      logic [31:0] random_bits;
      logic [7:0]  data_byte;
      logic        first_of_file;
      int          burst_left;
      int          pause_at;
      int          pick;
      bit          steady;

      // every block input known from time zero
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_NUMBER_ALL;
      csr_write_data       = 1'b0;
      req_ch.valid         = 1'b0;
      req_ch.data_byte     = 8'h00;
      req_ch.first_of_file = 1'b0;
      rsp_ch.ready         = 1'b0;

      // predictor starts from the reset state
      model_cfg        = CFG_PLAIN;
      model_count      = '0;
      model_line_start = 1'b1;
      model_prev_blank = 1'b0;

      mismatches       = 0;
      idle_cycles      = 0;
      bytes_sent       = 0;
      bytes_received   = 0;
      numbered_lines   = 0;
      squeezed_lines   = 0;
      settings_applied = 0;
      burst_left       = 0;

      // directed rows; typed runs are the ones obvious from the format rules
      directed_rows = '{
         // reset settings pass bytes through untouched
         '{CFG_PLAIN,        8'h41, 1'b1, FROM_TABLE,     "A"},
         '{CFG_PLAIN,        8'h00, 1'b0, FROM_PREDICTOR, ""},
         '{CFG_PLAIN,        8'hFF, 1'b0, FROM_PREDICTOR, ""},
         '{CFG_PLAIN,        8'h0A, 1'b0, FROM_TABLE,     "\n"},
         // number every line, blank ones too, with visible line ends
         '{CFG_LINES_ENDS,   8'h78, 1'b1, FROM_TABLE,     "     1\tx"},
         '{CFG_LINES_ENDS,   8'h0A, 1'b0, FROM_TABLE,     "$\n"},
         '{CFG_LINES_ENDS,   8'h0A, 1'b0, FROM_TABLE,     "     2\t$\n"},
         '{CFG_LINES_ENDS,   8'h09, 1'b0, FROM_TABLE,     "     3\t\t"},
         '{CFG_LINES_ENDS,   8'h0A, 1'b0, FROM_TABLE,     "$\n"},
         // everything on: nonblank numbering wins, high and control bytes in caret form
         '{CFG_EVERYTHING,   8'h80, 1'b1, FROM_TABLE,     "     1\tM-^@"},
         '{CFG_EVERYTHING,   8'hFF, 1'b0, FROM_TABLE,     "M-^?"},
         '{CFG_EVERYTHING,   8'h8A, 1'b0, FROM_TABLE,     "M-^J"},
         '{CFG_EVERYTHING,   8'h7F, 1'b0, FROM_TABLE,     "^?"},
         '{CFG_EVERYTHING,   8'h09, 1'b0, FROM_TABLE,     "^I"},
         '{CFG_EVERYTHING,   8'h1F, 1'b0, FROM_TABLE,     "^_"},
         '{CFG_EVERYTHING,   8'h0A, 1'b0, FROM_TABLE,     "$\n"},
         '{CFG_EVERYTHING,   8'h0A, 1'b0, FROM_TABLE,     "$\n"},
         // second blank line in a row is dropped
         '{CFG_EVERYTHING,   8'h0A, 1'b0, FROM_TABLE,     ""},
         '{CFG_EVERYTHING,   8'h20, 1'b0, FROM_TABLE,     "     2\t "},
         '{CFG_EVERYTHING,   8'h0A, 1'b0, FROM_TABLE,     "$\n"},
         // nonprinting alone leaves newline and tab raw
         '{CFG_NONPRINT,     8'h0A, 1'b1, FROM_TABLE,     "\n"},
         '{CFG_NONPRINT,     8'h09, 1'b0, FROM_TABLE,     "\t"},
         '{CFG_NONPRINT,     8'h7E, 1'b0, FROM_TABLE,     "~"},
         // squeeze without numbering; a new file clears the blank mark
         '{CFG_TABS_SQUEEZE, 8'h0A, 1'b1, FROM_TABLE,     "\n"},
         '{CFG_TABS_SQUEEZE, 8'h0A, 1'b0, FROM_TABLE,     ""},
         '{CFG_TABS_SQUEEZE, 8'h09, 1'b0, FROM_TABLE,     "^I"}
      };

      // synchronous reset, released on a falling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table; settings change only with the block drained
      foreach (directed_rows[r]) begin
         if (directed_rows[r].cfg !== model_cfg) begin
            wait_for_drain();
            apply_settings(directed_rows[r].cfg);
         end
         send_byte(directed_rows[r].data_byte, directed_rows[r].first_of_file,
                   directed_rows[r].answer, directed_rows[r].typed_run);
      end

      // random text, one settings mix per phase, both extremes first
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_drain();
         random_bits = $urandom;
         case (phase)
            0:       phase_cfg = CFG_EVERYTHING;
            1:       phase_cfg = CFG_PLAIN;
            default: phase_cfg = cfg_type'(random_bits[$bits(cfg_type)-1:0]);
         endcase
         apply_settings(phase_cfg);
         // one phase streams back to back with no random sender gaps, apart from the drain pause
         steady   = (phase == 2);
         pause_at = $urandom_range(4, ITEMS_PER_PHASE - 4);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // sender holds off until the output side has caught up
            if (n == pause_at) wait_for_drain();
            if (!steady && burst_left <= 0) begin
               if ($urandom_range(0, 3) != 0) begin
                  req_ch.valid     <= 1'b0;
                  req_ch.data_byte <= 8'($urandom);
                  repeat ($urandom_range(1, 8)) @(negedge clock);
               end
               burst_left = $urandom_range(1, 20);
            end
            // mostly text lines, runs of newlines for squeezing, some raw binary
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               data_byte = 8'($urandom_range(32, 126));
            end else if (pick < 65) begin
               data_byte = CHR_NL;
            end else if (pick < 72) begin
               data_byte = CHR_TAB;
            end else if (pick < 82) begin
               data_byte = 8'($urandom_range(0, 31));
            end else if (pick < 86) begin
               data_byte = CHR_DEL;
            end else begin
               data_byte = 8'($urandom_range(128, 255));
            end
            first_of_file = ($urandom_range(0, 19) == 0);
            send_byte(data_byte, first_of_file, FROM_PREDICTOR, "");
            burst_left--;
         end
      end

      // everything out, plus a settle time to catch stray output
      wait_for_drain();

      $display("run covered %0d input and %0d output transactions over %0d settings,",
               bytes_sent, bytes_received, settings_applied);
      $display("with %0d numbered lines and %0d squeezed blank lines",
               numbered_lines, squeezed_lines);
      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d bytes never seen", mismatches, pending_bytes.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
